// ===== sv/exsort_pkg.sv =====
// Shared constants and types for the exchange sort block.
// Used by exchange_sort_asc_desc; depends on nothing.
`default_nettype none

package exsort_pkg;

    localparam int MAX_ELEMENTS = 32;
    localparam int DATA_W       = 32;
    localparam int IDX_W        = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 3;
    localparam int REG_IDX_W    = APB_ADDR_W - 2;

    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [DATA_W-1:0]    t_data;
    typedef logic [REG_IDX_W-1:0] t_reg_idx;

    // Register index of the direction bit.
    localparam t_reg_idx REG_DESCENDING = t_reg_idx'(0);

endpackage

`default_nettype wire

// ===== sv/exsort_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the element store of the exchange sort block.
`default_nettype none

module exsort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== sv/exchange_sort_asc_desc.sv =====
// Exchange sort of signed 32-bit values: load, sort in place, stream out.
// Depends on exsort_pkg and exsort_ram (element store).
//
//  Channel   Direction  Signals                          Beat contents
//  s stream  in         i_s_tvalid/o_s_tready            tdata value_in, tlast last_in
//  m stream  out        o_m_tvalid/i_m_tready            tdata value_out, tlast last_out,
//                                                        tuser overflowed
//  APB       in         i_psel/i_penable/i_pwrite/...    reg 0 at 0x0: descending
//
// Loading accepts one input beat per cycle; the block is ready only while loading.
// After the closing beat of a set of n >= 2 elements the sort runs at most one
// compare of the shared comparator per cycle, bounded by the single read and
// write port of the store; a set of fewer elements goes straight to output.
// Each output beat passes through a store read and the output register, plus any stall.
// Synchronous active-low reset clears the count, overflow flag and direction.
`default_nettype none

module exchange_sort_asc_desc (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Input stream
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    input  wire logic [exsort_pkg::DATA_W-1:0]      i_s_tdata,  // [31:0] value_in
    input  wire logic                               i_s_tlast,  // last_in
    // Output stream
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    output logic      [exsort_pkg::DATA_W-1:0]      o_m_tdata,  // [31:0] value_out
    output logic                                    o_m_tlast,  // last_out
    output logic                                    o_m_tuser,  // [0] overflowed
    // Configuration port
    input  wire logic                               i_psel,
    input  wire logic                               i_penable,
    input  wire logic                               i_pwrite,
    input  wire logic [exsort_pkg::APB_ADDR_W-1:0]  i_paddr,
    input  wire logic [exsort_pkg::APB_DATA_W-1:0]  i_pwdata,
    output logic      [exsort_pkg::APB_DATA_W-1:0]  o_prdata,
    output logic                                    o_pready
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_START,
        S_LDI,
        S_CMP,
        S_WBI,
        S_ORD,
        S_OLD,
        S_OWAIT
    } t_state;

    t_state                r_state, n_state;
    exsort_pkg::t_cnt      r_count, n_count;
    exsort_pkg::t_cnt      r_i, n_i;
    exsort_pkg::t_cnt      r_j, n_j;
    exsort_pkg::t_data     r_vi, n_vi;
    exsort_pkg::t_data     r_mdata, n_mdata;
    logic                  r_ovf, n_ovf;
    logic                  r_desc;

    logic                  ram_we;
    exsort_pkg::t_idx      ram_waddr;
    exsort_pkg::t_data     ram_wdata;
    exsort_pkg::t_idx      ram_raddr;
    exsort_pkg::t_data     ram_rdata;

    logic                  swap;
    logic                  cfg_wr;
    exsort_pkg::t_reg_idx  reg_idx;
    exsort_pkg::t_cnt      i_plus1;
    exsort_pkg::t_cnt      i_plus2;
    exsort_pkg::t_cnt      j_plus1;

    exsort_ram #(
        .WIDTH (exsort_pkg::DATA_W),
        .DEPTH (exsort_pkg::MAX_ELEMENTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign reg_idx  = i_paddr[exsort_pkg::APB_ADDR_W-1:2];
    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready &&
                      (reg_idx == exsort_pkg::REG_DESCENDING);
    assign o_pready = 1'b1;
    assign o_prdata = (reg_idx == exsort_pkg::REG_DESCENDING)
                    ? {{(exsort_pkg::APB_DATA_W-1){1'b0}}, r_desc}
                    : '0;

    assign i_plus1 = exsort_pkg::t_cnt'(r_i + exsort_pkg::t_cnt'(1));
    assign i_plus2 = exsort_pkg::t_cnt'(r_i + exsort_pkg::t_cnt'(2));
    assign j_plus1 = exsort_pkg::t_cnt'(r_j + exsort_pkg::t_cnt'(1));

    // The shared comparator: r_vi holds the running winner for position i,
    // the store read returns position j.
    assign swap = r_desc ? ($signed(ram_rdata) > $signed(r_vi))
                         : ($signed(r_vi) > $signed(ram_rdata));

    assign o_s_tready = (r_state == S_LOAD);
    assign o_m_tvalid = (r_state == S_OWAIT);
    assign o_m_tdata  = r_mdata;
    assign o_m_tlast  = (i_plus1 == r_count);
    assign o_m_tuser  = r_ovf;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_i       = r_i;
        n_j       = r_j;
        n_vi      = r_vi;
        n_mdata   = r_mdata;
        n_ovf     = r_ovf;
        ram_we    = 1'b0;
        ram_waddr = r_i[exsort_pkg::IDX_W-1:0];
        ram_wdata = r_vi;
        ram_raddr = r_i[exsort_pkg::IDX_W-1:0];
        case (r_state)
            S_LOAD: begin
                if (i_s_tvalid) begin
                    if (r_count < exsort_pkg::CNT_W'(exsort_pkg::MAX_ELEMENTS)) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_count[exsort_pkg::IDX_W-1:0];
                        ram_wdata = i_s_tdata;
                        n_count   = exsort_pkg::t_cnt'(r_count + exsort_pkg::t_cnt'(1));
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_s_tlast) begin
                        n_i     = '0;
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                // r_i is zero here, so the read of entry 0 serves both paths.
                if (r_count < exsort_pkg::t_cnt'(2)) begin
                    n_state = S_OLD;
                end else begin
                    n_j     = i_plus1;
                    n_state = S_LDI;
                end
            end
            S_LDI: begin
                n_vi      = ram_rdata;
                ram_raddr = r_j[exsort_pkg::IDX_W-1:0];
                n_state   = S_CMP;
            end
            S_CMP: begin
                if (swap) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_j[exsort_pkg::IDX_W-1:0];
                    ram_wdata = r_vi;
                    n_vi      = ram_rdata;
                end
                ram_raddr = j_plus1[exsort_pkg::IDX_W-1:0];
                n_j       = j_plus1;
                if (j_plus1 == r_count) begin
                    n_state = S_WBI;
                end
            end
            S_WBI: begin
                ram_we    = 1'b1;
                ram_waddr = r_i[exsort_pkg::IDX_W-1:0];
                ram_wdata = r_vi;
                if (i_plus2 < r_count) begin
                    ram_raddr = i_plus1[exsort_pkg::IDX_W-1:0];
                    n_i       = i_plus1;
                    n_j       = i_plus2;
                    n_state   = S_LDI;
                end else begin
                    n_i       = '0;
                    n_state   = S_ORD;
                end
            end
            S_ORD: begin
                // Entry 0 may have been written on the previous edge, so it is
                // read only now.
                n_state = S_OLD;
            end
            S_OLD: begin
                n_mdata = ram_rdata;
                n_state = S_OWAIT;
            end
            S_OWAIT: begin
                // Prefetch the next entry so the store read holds it in the cycle after the beat.
                ram_raddr = i_plus1[exsort_pkg::IDX_W-1:0];
                if (i_m_tready) begin
                    if (i_plus1 == r_count) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_i     = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_i     = i_plus1;
                        n_state = S_OLD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_ovf   <= 1'b0;
            r_desc  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_i     <= n_i;
            r_j     <= n_j;
            r_ovf   <= n_ovf;
            if (cfg_wr) begin
                r_desc <= i_pwdata[0];
            end
        end
        r_vi    <= n_vi;
        r_mdata <= n_mdata;
    end

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input and output sides active together");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= exsort_pkg::CNT_W'(exsort_pkg::MAX_ELEMENTS))
        else $error("element count beyond capacity");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_count == exsort_pkg::CNT_W'(exsort_pkg::MAX_ELEMENTS)))
        else $error("overflow flagged with room left in the store");

    a_cmp_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> ((r_j > r_i) && (r_j < r_count)))
        else $error("compare indexes out of order");

    a_last_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast) |=> (o_s_tready && (r_count == '0)))
        else $error("block not back to loading after the final beat");
`endif

endmodule

`default_nettype wire
